### rtl/core/egcd_pkg.sv
// Shared constants, widths and controller/datapath interface structs
// for the extended gcd block. No dependencies.
package egcd_pkg;

    localparam int DATA_WIDTH  = 31;
    localparam int COEF_WIDTH  = DATA_WIDTH + 1;
    localparam int MAX_STEPS   = 48;
    localparam int QN_W        = $clog2(MAX_STEPS + 1);
    localparam int ADDR_W      = $clog2(MAX_STEPS);
    localparam int CNT_W       = $clog2(DATA_WIDTH);
    localparam int IN_TDATA_W  = ((2 * DATA_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((DATA_WIDTH + 2 * COEF_WIDTH + 7) / 8) * 8;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_in;
        logic start_div;
        logic div_step;
        logic store;
        logic bs_init;
        logic bs_read;
        logic bs_mul;
        logic bs_upd;
        logic out_load;
        logic out_err;
    } egcd_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic both_zero;
        logic r1_zero;
        logic qn_full;
        logic div_last;
        logic k_zero;
        logic out_free;
    } egcd_sts_t;

endpackage

### rtl/core/egcd_dp.sv
// Datapath: operand registers, bit-serial divider, quotient memory and
// back-substitution multiply/subtract. Depends on egcd_pkg.
module egcd_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  egcd_pkg::egcd_cmd_t              cmd,
    output egcd_pkg::egcd_sts_t              sts,
    input  logic [egcd_pkg::IN_TDATA_W-1:0]  in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [egcd_pkg::OUT_TDATA_W-1:0] out_data,
    output logic                             out_bad
);
    import egcd_pkg::*;

    logic [DATA_WIDTH-1:0] r0_reg, r1_reg, rem_reg, quo_reg, rd_reg;
    logic                  a_big_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [QN_W-1:0]       qn_reg, k_reg, k_dec;
    logic [COEF_WIDTH-1:0] sp_reg, sc_reg, prod_reg;
    logic [DATA_WIDTH-1:0] quot_mem [MAX_STEPS];

    logic [DATA_WIDTH-1:0] a_in, b_in, rem_next;
    logic [DATA_WIDTH:0]   trial, diff;
    logic                  ge;
    logic [2*COEF_WIDTH-1:0] prod_full;
    logic                  out_valid_reg, out_bad_reg;
    logic [DATA_WIDTH-1:0] out_div_reg;
    logic [COEF_WIDTH-1:0] out_c1_reg, out_c2_reg;

    assign a_in = in_data[DATA_WIDTH-1:0];
    assign b_in = in_data[2*DATA_WIDTH-1:DATA_WIDTH];

    // One restoring division step: shift in next dividend bit, try subtract
    assign trial    = {rem_reg, quo_reg[DATA_WIDTH-1]};
    assign diff     = trial - {1'b0, r1_reg};
    assign ge       = (trial >= {1'b0, r1_reg});
    assign rem_next = ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];

    assign k_dec     = k_reg - 1'b1;
    assign prod_full = sc_reg * {{(COEF_WIDTH-DATA_WIDTH){1'b0}}, rd_reg};

    // Status back to the controller
    assign sts.both_zero = (r0_reg == '0);
    assign sts.r1_zero   = (r1_reg == '0);
    assign sts.qn_full   = (qn_reg == QN_W'(MAX_STEPS));
    assign sts.div_last  = (cnt_reg == CNT_W'(DATA_WIDTH - 1));
    assign sts.k_zero    = (k_reg == '0);
    assign sts.out_free  = !out_valid_reg || out_ready;

    // Operand, divider and back-substitution registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            a_big_reg <= (a_in >= b_in);
            r0_reg    <= (a_in >= b_in) ? a_in : b_in;
            r1_reg    <= (a_in >= b_in) ? b_in : a_in;
            qn_reg    <= '0;
        end
        if (cmd.start_div) begin
            rem_reg <= '0;
            quo_reg <= r0_reg;
            cnt_reg <= '0;
        end
        if (cmd.div_step) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DATA_WIDTH-2:0], ge};
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.store) begin
            quot_mem[qn_reg[ADDR_W-1:0]] <= quo_reg;
            r0_reg <= r1_reg;
            r1_reg <= rem_reg;
            qn_reg <= qn_reg + 1'b1;
        end
        if (cmd.bs_init) begin
            sp_reg <= (qn_reg == '0) ? COEF_WIDTH'(1) : '0;
            sc_reg <= (qn_reg == '0) ? '0 : COEF_WIDTH'(1);
            k_reg  <= (qn_reg == '0) ? '0 : qn_reg - 1'b1;
        end
        if (cmd.bs_read) begin
            rd_reg <= quot_mem[k_dec[ADDR_W-1:0]];
            k_reg  <= k_dec;
        end
        if (cmd.bs_mul) begin
            prod_reg <= prod_full[COEF_WIDTH-1:0];
        end
        if (cmd.bs_upd) begin
            sp_reg <= sc_reg;
            sc_reg <= sp_reg - prod_reg;
        end
    end

    // Result register: hold until transfer, coefficients in input order
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_bad_reg <= cmd.out_err;
            out_div_reg <= cmd.out_err ? '0 : r0_reg;
            out_c1_reg  <= cmd.out_err ? '0 : (a_big_reg ? sp_reg : sc_reg);
            out_c2_reg  <= cmd.out_err ? '0 : (a_big_reg ? sc_reg : sp_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_bad   = out_bad_reg;
    assign out_data  = {{(OUT_TDATA_W-DATA_WIDTH-2*COEF_WIDTH){1'b0}},
                        out_c2_reg, out_c1_reg, out_div_reg};

endmodule

### rtl/core/egcd_ctrl.sv
// Controller state machine sequencing divide steps and back-substitution.
// Depends on egcd_pkg.
module egcd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  egcd_pkg::egcd_sts_t sts,
    output egcd_pkg::egcd_cmd_t cmd
);
    import egcd_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_CHECK = 9'b000000010,
        ST_DIV   = 9'b000000100,
        ST_STORE = 9'b000001000,
        ST_BSEL  = 9'b000010000,
        ST_BREAD = 9'b000100000,
        ST_BMUL  = 9'b001000000,
        ST_BUPD  = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   err_reg, err_next;

    // Advance state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            err_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            err_reg   <= err_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        err_next   = err_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load_in = 1'b1;
                    err_next    = 1'b0;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.both_zero) begin
                    err_next   = 1'b1;
                    state_next = ST_DONE;
                end else if (sts.r1_zero) begin
                    cmd.bs_init = 1'b1;
                    state_next  = ST_BSEL;
                end else if (sts.qn_full) begin
                    err_next   = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    cmd.start_div = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) state_next = ST_STORE;
            end
            ST_STORE: begin
                cmd.store  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_BSEL: begin
                state_next = sts.k_zero ? ST_DONE : ST_BREAD;
            end
            ST_BREAD: begin
                cmd.bs_read = 1'b1;
                state_next  = ST_BMUL;
            end
            ST_BMUL: begin
                cmd.bs_mul = 1'b1;
                state_next = ST_BUPD;
            end
            ST_BUPD: begin
                cmd.bs_upd = 1'b1;
                state_next = ST_BSEL;
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_err  = err_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

### rtl/core/extended_gcd_bezout.sv
// Top level of the extended gcd block: joins controller and datapath.
// Depends on egcd_pkg, egcd_ctrl and egcd_dp.
//
// Takes two unsigned operands and returns their gcd with one Bezout
// coefficient per operand (a*first_coef + b*second_coef = gcd), coefficients
// in input order; both operands zero gives an all-zero result with bad_input
// set. One item is in work at a time. Each remainder step runs all
// DATA_WIDTH bits through the bit-serial divider, then stores the quotient
// and tests the new remainder; each back-substitution step is a loop test,
// quotient memory read, multiply and subtract. The result waits in an
// output register; s_tready rises again once it is loaded there.
module extended_gcd_bezout (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata: first_value, second_value
    input  logic [egcd_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata: divisor, first_coef, second_coef
    output logic [egcd_pkg::OUT_TDATA_W-1:0] m_tdata,
    // m_tuser: bad_input
    output logic                             m_tuser
);
    import egcd_pkg::*;

    egcd_cmd_t cmd;
    egcd_sts_t sts;

    egcd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    egcd_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_bad   (m_tuser)
    );

endmodule

### rtl/core/egcd_checker.sv
// Port-level checks for the extended gcd block, bound to the top level.
// Depends on egcd_pkg.
module egcd_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [egcd_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                             m_tuser
);
    import egcd_pkg::*;

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Error result is all zero
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[DATA_WIDTH+2*COEF_WIDTH-1:0] == '0)
        else $error("error result not zero");

    // A good result has a non-zero gcd
    a_gcd_nz: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[DATA_WIDTH-1:0] != '0)
        else $error("zero gcd without error");

    // Busy after an input transfer
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

endmodule

bind extended_gcd_bezout egcd_checker u_egcd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
